[hw/rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// Pressure compensation package
// Shared types, constants and status codes.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DIVZ   = 2'd1,
      STATUS_SAT    = 2'd2,
      STATUS_UNUSED = 2'd3
   } status_type;

   localparam logic [1:0] CSR_A = 2'd0;
   localparam logic [1:0] CSR_B = 2'd1;
   localparam logic [1:0] CSR_C = 2'd2;

   localparam logic signed [31:0] C_3038  = 32'sd3038;
   localparam logic signed [31:0] C_M7357 = -32'sd7357;
   localparam logic signed [31:0] C_3791  = 32'sd3791;
   localparam logic [31:0]        C_50000 = 32'd50000;
   localparam logic signed [31:0] C_4000  = 32'sd4000;
   localparam logic [31:0]        C_32768 = 32'd32768;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [15:0] raw_press;
   } item_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic [17:0]        press_pa;
      logic [1:0]         status;
   } result_type;

endpackage

[hw/rtl/bpc_divider.sv]
// ----------------------------------------------------------------------------
// Pressure compensation divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[31]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

[hw/rtl/bpc_front.sv]
// ----------------------------------------------------------------------------
// Pressure compensation front
// Accepts raw readings into a short queue.
// ----------------------------------------------------------------------------
module bpc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  bpc_pkg::item_type item_in,
   input  logic              take,
   output logic              avail,
   output bpc_pkg::item_type item_out
);
   bpc_pkg::item_type mem_ff [bpc_pkg::QDEPTH];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full  = (cnt_ff == 2'(bpc_pkg::QDEPTH));
   assign avail = (cnt_ff != 2'd0);
   assign do_push = push && !full;
   assign do_pop  = take && avail;
   assign item_out = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= item_in;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(bpc_pkg::QDEPTH)) else $error("queue overflow");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !do_pop) else $error("pop from empty");
   a_keep: assert property (@(posedge clock) disable iff (reset)
      (avail && !do_pop) |=> avail) else $error("item lost");
endmodule

[hw/rtl/bpc_back.sv]
// ----------------------------------------------------------------------------
// Pressure compensation back end
// Sequenced datapath: at most one multiply and one divide start per step, shared divider.
// ----------------------------------------------------------------------------
module bpc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         cal_a,
   input  logic [63:0]         cal_b,
   input  logic [31:0]         cal_c,
   input  logic                avail,
   output logic                take,
   input  bpc_pkg::item_type   item,
   output logic                rsp_valid,
   input  logic                rsp_taken,
   output bpc_pkg::result_type rsp
);
   typedef enum logic [17:0] {
      S_IDLE = 18'h00001, S_X1  = 18'h00002, S_D   = 18'h00004,
      S_X2W  = 18'h00008, S_B5  = 18'h00010, S_SQ  = 18'h00020,
      S_B2   = 18'h00040, S_AC2 = 18'h00080, S_B3  = 18'h00100,
      S_AC3  = 18'h00200, S_B1  = 18'h00400, S_B4  = 18'h00800,
      S_B7   = 18'h01000, S_PW  = 18'h02000, S_P1  = 18'h04000,
      S_P2   = 18'h08000, S_P3  = 18'h10000, S_OUT = 18'h20000
   } st_type;

   st_type st_ff, st_in;
   logic signed [31:0] x1_ff, b5_ff, b6_ff, sq_ff, x3_ff, b3_ff, p_ff, t_ff, acc_ff;
   logic signed [31:0] x1_in, b5_in, b6_in, sq_in, x3_in, b3_in, p_in, t_in, acc_in;
   logic [31:0] b4_ff, b4_in, b7_ff, b7_in;
   logic        neg_ff, neg_in, sat_ff, sat_in, dz_ff, dz_in;
   logic [15:0] ut_ff, ut_in, up_ff, up_in;
   logic        full_ff, full_in;
   bpc_pkg::result_type res_ff, res_in;
   bpc_pkg::result_type res_nx_ff, res_nx_in;

   logic        dstart, ddone;
   logic [31:0] dnum, dden, dq;

   logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [31:0] ac4, ac5, ac6;
   logic signed [31:0] m_a, m_b, m_p, tq, tmp, pn;
   logic [31:0] pu;

   assign ac1 = 32'(signed'(cal_a[15:0]));
   assign ac2 = 32'(signed'(cal_a[31:16]));
   assign ac3 = 32'(signed'(cal_a[47:32]));
   assign ac4 = {16'd0, cal_a[63:48]};
   assign ac5 = {16'd0, cal_b[15:0]};
   assign ac6 = {16'd0, cal_b[31:16]};
   assign b1  = 32'(signed'(cal_b[47:32]));
   assign b2  = 32'(signed'(cal_b[63:48]));
   assign mc  = 32'(signed'(cal_c[15:0]));
   assign md  = 32'(signed'(cal_c[31:16]));

   bpc_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnum),
      .divisor(dden), .done(ddone), .quotient(dq)
   );

   assign take = (st_ff == S_IDLE) && avail;
   assign rsp_valid = full_ff;
   assign rsp = res_ff;

   always_comb begin
      st_in = st_ff; x1_in = x1_ff; b5_in = b5_ff; b6_in = b6_ff; sq_in = sq_ff;
      x3_in = x3_ff; b3_in = b3_ff; p_in = p_ff; t_in = t_ff; acc_in = acc_ff;
      b4_in = b4_ff; b7_in = b7_ff; neg_in = neg_ff; sat_in = sat_ff; dz_in = dz_ff;
      ut_in = ut_ff; up_in = up_ff; full_in = full_ff; res_in = res_ff;
      res_nx_in = res_nx_ff;
      dstart = 1'b0; dnum = '0; dden = '0;
      m_a = '0; m_b = '0; tq = '0; tmp = '0; pn = '0; pu = '0;
      if (full_ff && rsp_taken) full_in = 1'b0;
      m_p = 32'(m_a * m_b);
      unique case (st_ff)
         S_IDLE: if (take) begin
            ut_in = item.raw_temp; up_in = item.raw_press; sat_in = 1'b0;
            dz_in = 1'b0; st_in = S_X1;
         end
         S_X1: begin
            m_a = {16'd0, ut_ff} - ac6; m_b = ac5; m_p = 32'(m_a * m_b);
            x1_in = m_p >>> 15; st_in = S_D;
         end
         S_D: begin
            tmp = x1_ff + md;
            acc_in = tmp;
            if (tmp == 32'sd0) begin
               res_nx_in = '{temp_tenths: '0, press_pa: '0, status: bpc_pkg::STATUS_DIVZ};
               st_in = S_OUT;
            end else begin
               tq = mc <<< 11;
               neg_in = tq[31] ^ tmp[31];
               dnum = tq[31] ? 32'(-tq) : tq;
               dden = tmp[31] ? 32'(-tmp) : tmp;
               dstart = 1'b1; st_in = S_X2W;
            end
         end
         S_X2W: if (ddone) begin
            tq = neg_ff ? 32'(-signed'(dq)) : signed'(dq);
            b5_in = x1_ff + tq; st_in = S_B5;
         end
         S_B5: begin
            tmp = (b5_ff + 32'sd8) >>> 4;
            if (tmp > 32'sd32767) begin t_in = 32'sd32767; sat_in = 1'b1; end
            else if (tmp < -32'sd32768) begin t_in = -32'sd32768; sat_in = 1'b1; end
            else t_in = tmp;
            b6_in = b5_ff - bpc_pkg::C_4000; st_in = S_SQ;
         end
         S_SQ: begin
            m_a = b6_ff; m_b = b6_ff; m_p = 32'(m_a * m_b);
            sq_in = m_p >>> 12; st_in = S_B2;
         end
         S_B2: begin
            m_a = b2; m_b = sq_ff; m_p = 32'(m_a * m_b);
            acc_in = m_p >>> 11; st_in = S_AC2;
         end
         S_AC2: begin
            m_a = ac2; m_b = b6_ff; m_p = 32'(m_a * m_b);
            x3_in = acc_ff + (m_p >>> 11); st_in = S_B3;
         end
         S_B3: begin
            tmp = (ac1 <<< 2) + x3_ff + 32'sd2;
            b3_in = (tmp + (tmp[31] ? 32'sd3 : 32'sd0)) >>> 2;
            st_in = S_AC3;
         end
         S_AC3: begin
            m_a = ac3; m_b = b6_ff; m_p = 32'(m_a * m_b);
            acc_in = m_p >>> 13; st_in = S_B1;
         end
         S_B1: begin
            m_a = b1; m_b = sq_ff; m_p = 32'(m_a * m_b);
            x3_in = (acc_ff + (m_p >>> 16) + 32'sd2) >>> 2; st_in = S_B4;
         end
         S_B4: begin
            b4_in = 32'(ac4 * 32'(x3_ff + bpc_pkg::C_32768)) >> 15;
            st_in = S_B7;
         end
         S_B7: begin
            if (b4_ff == 32'd0) begin
               dz_in = 1'b1; p_in = '0; st_in = S_OUT;
               res_nx_in = '{temp_tenths: t_ff[15:0], press_pa: '0,
                             status: bpc_pkg::STATUS_DIVZ};
            end else begin
               tmp = 32'({16'd0, up_ff} - b3_ff);
               b7_in = 32'(tmp) * bpc_pkg::C_50000;
               dnum = b7_in[31] ? b7_in : {b7_in[30:0], 1'b0};
               dden = b4_ff; dstart = 1'b1; st_in = S_PW;
            end
         end
         S_PW: if (ddone) begin
            pu = b7_ff[31] ? {dq[30:0], 1'b0} : dq;
            p_in = signed'(pu);
            acc_in = signed'(pu) >>> 8; st_in = S_P1;
         end
         S_P1: begin
            m_a = acc_ff; m_b = acc_ff; m_p = 32'(m_a * m_b);
            acc_in = m_p; st_in = S_P2;
         end
         S_P2: begin
            m_a = acc_ff; m_b = bpc_pkg::C_3038; m_p = 32'(m_a * m_b);
            acc_in = m_p >>> 16; st_in = S_P3;
         end
         S_P3: begin
            m_a = bpc_pkg::C_M7357; m_b = p_ff; m_p = 32'(m_a * m_b);
            pn = p_ff + ((acc_ff + (m_p >>> 16) + bpc_pkg::C_3791) >>> 4);
            res_nx_in.temp_tenths = t_ff[15:0];
            if (pn < 32'sd0) begin
               res_nx_in.press_pa = '0; res_nx_in.status = bpc_pkg::STATUS_SAT;
            end else if (pn > 32'sd262143) begin
               res_nx_in.press_pa = 18'h3FFFF; res_nx_in.status = bpc_pkg::STATUS_SAT;
            end else begin
               res_nx_in.press_pa = pn[17:0];
               res_nx_in.status = sat_ff ? bpc_pkg::STATUS_SAT : bpc_pkg::STATUS_OK;
            end
            st_in = S_OUT;
         end
         S_OUT: if (!full_ff || rsp_taken) begin
            res_in = res_nx_ff; full_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in; b5_ff <= b5_in; b6_ff <= b6_in; sq_ff <= sq_in; x3_ff <= x3_in;
      b3_ff <= b3_in; p_ff <= p_in; t_ff <= t_in; acc_ff <= acc_in; b4_ff <= b4_in;
      b7_ff <= b7_in; neg_ff <= neg_in; sat_ff <= sat_in; dz_ff <= dz_in;
      ut_ff <= ut_in; up_ff <= up_in; res_ff <= res_in; res_nx_ff <= res_nx_in;
      if (reset) begin
         st_ff <= S_IDLE; full_ff <= 1'b0;
      end else begin
         st_ff <= st_in; full_ff <= full_in;
      end
   end

   a_oh: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (full_ff && !rsp_taken) |=> (full_ff && $stable(res_ff))) else $error("result lost");
   a_st: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (res_ff.status != bpc_pkg::STATUS_UNUSED)) else $error("bad status");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_PW) |-> !dz_ff) else $error("divide after zero divisor");
endmodule

[hw/rtl/barometric_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Integer temperature and pressure compensation with packed calibration.
//
// channel | direction | handshake        | payload
// req     | in        | push / full      | raw_temp, raw_press
// rsp     | out       | pop / empty      | temp_tenths, press_pa, status
// csr     | in        | valid / ready    | index, data
//
// An item takes two passes of the shared divider; none when the temperature
// divisor is zero, one when the pressure divisor is zero.
// A two-word queue takes new words while the back end works.
// Reset clears queue, sequencer and calibration registers.
// A full result register stalls the back end, not the input queue.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [15:0]        req_raw_temp,
   input  logic [15:0]        req_raw_press,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_temp_tenths,
   output logic [17:0]        rsp_press_pa,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_data
);
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic        avail, take, rvalid;
   bpc_pkg::item_type   qin, qout;
   bpc_pkg::result_type res;

   assign csr_ready = 1'b1;
   assign qin = '{raw_temp: req_raw_temp, raw_press: req_raw_press};

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0; cal_b_ff <= '0; cal_c_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == bpc_pkg::CSR_A) cal_a_ff <= csr_data;
         if (csr_index == bpc_pkg::CSR_B) cal_b_ff <= csr_data;
         if (csr_index == bpc_pkg::CSR_C) cal_c_ff <= csr_data[31:0];
      end
   end

   bpc_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .item_in(qin),
      .take(take), .avail(avail), .item_out(qout)
   );

   bpc_back u_back (
      .clock(clock), .reset(reset), .cal_a(cal_a_ff), .cal_b(cal_b_ff),
      .cal_c(cal_c_ff), .avail(avail), .take(take), .item(qout),
      .rsp_valid(rvalid), .rsp_taken(pop), .rsp(res)
   );

   assign empty = !rvalid;
   assign rsp_temp_tenths = res.temp_tenths;
   assign rsp_press_pa = res.press_pa;
   assign rsp_status = res.status;
endmodule
